### rtl/md5sh_pkg.sv
// Package for the MD5 stream hasher: controller states, round constants,
// message schedule and shift amounts. No dependencies.
package md5sh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam int          BLOCK_WORDS = 16;
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic        OP_START = 1'b0;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // word of the block that step i reads
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] r;
    unique case (i[5:4])
      2'd0: r = i[3:0];
      2'd1: r = 4'((5 * i + 1) & 15);
      2'd2: r = 4'((3 * i + 5) & 15);
      default: r = 4'((7 * i) & 15);
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
      4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

### rtl/md5sh_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module md5sh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/md5sh_round.sv
// One MD5 step on the working registers, one step per cycle.
// Depends on md5sh_pkg.
module md5sh_round
  import md5sh_pkg::*;
(
  input  logic [5:0]  step,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] m,
  output logic [31:0] b_new
);
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] dbl;

  always_comb begin
    unique case (step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    t = a + f + m + K_TAB[step];
    dbl = {t, t} << rot_amount(step);
    b_new = b + dbl[63:32];
  end
endmodule

### rtl/md5_stream_hasher.sv
// MD5 stream hasher, top level: input packing, block buffer RAM, control.
// Depends on md5sh_pkg, md5sh_ram and md5sh_round.
//
// Usage: items arrive on the s_axis channel; tdata carries message_word and
// valid_bytes, tuser carries operation, tlast marks the final word. A start
// item (operation 0) reloads the chaining words and clears the length. Data
// words are packed byte by byte into a 16-word block RAM, one transfer per
// cycle while idle. The block that fills starts a compression: a lead-in
// read and 64 steps, one per cycle, reading the block RAM one word ahead
// (registered read), then a fold into the chaining words. A last word is
// followed by padding writes, one word a cycle, and one or two compressions,
// after which m_axis_tvalid rises. The digest then waits on m_axis until
// taken, and no new item is accepted meanwhile. After the digest the block
// is back in the start state. Reset returns to idle with the initial
// chaining words and zero length; the block RAM keeps its contents.
module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // message_word[31:0], valid_bytes[34:32], zero
  input  logic         s_axis_tuser,   // operation
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_a, digest_b, digest_c, digest_d
);
  localparam int AW = $clog2(BLOCK_WORDS);

  state_t state, state_next;
  logic [31:0] h [4];
  logic [31:0] ra, rb, rc, rd;
  logic [5:0]  fill;              // bytes held in the block
  logic [63:0] bitlen;
  logic [6:0]  step;              // 64 steps plus a lead-in read
  logic [3:0]  padw;              // padding word being written
  logic        final_blk;         // current compression belongs to a last word
  logic        need_two;          // another pad block follows this compression
  logic [31:0] word_hold;         // partial word at fill, or the spill of a last word

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  logic [31:0]   b_new;

  logic        in_fire;
  logic [31:0] in_word;
  logic [2:0]  in_nv, nv;
  logic [6:0]  fill_sum;
  logic        crossed;
  logic [63:0] merged;

  // held bytes, then the new bytes, then the marker byte on a last word
  function automatic logic [63:0] merge_bytes(input logic [31:0] old_w,
                                              input logic [31:0] new_w,
                                              input logic [1:0]  off,
                                              input logic [2:0]  cnt,
                                              input logic        pad);
    logic [63:0] r;
    logic [2:0]  p;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      p = 3'(k) - {1'b0, off};
      if (k < int'(off)) begin
        r[8*k +: 8] = old_w[8*(k & 3) +: 8];
      end else if (p < cnt) begin
        r[8*k +: 8] = new_w[8*p[1:0] +: 8];
      end else if (p == cnt && pad) begin
        r[8*k +: 8] = PAD_BYTE;
      end
    end
    return r;
  endfunction

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_word = s_axis_tdata[31:0];
  assign in_nv   = s_axis_tdata[34:32];
  assign nv      = (in_nv > 3'd4) ? 3'd4 : in_nv;
  assign fill_sum = 7'(fill) + 7'(nv);
  assign crossed  = (fill_sum[6:2] != {1'b0, fill[5:2]});
  assign merged   = merge_bytes(word_hold, in_word, fill[1:0], nv, s_axis_tlast);

  md5sh_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  md5sh_round u_round (
    .step(step[5:0] - 6'd1), .a(ra), .b(rb), .c(rc), .d(rd),
    .m(rdata), .b_new(b_new)
  );

  // The partial word is held in word_hold so the RAM needs no read-modify.
  // Pad words: the held spill first, zeros after, the length at the end.
  always_comb begin
    we    = 1'b0;
    waddr = fill[5:2];
    wdata = '0;
    raddr = msg_index(step[5:0]);
    if (in_fire && s_axis_tuser != OP_START) begin
      we    = 1'b1;
      wdata = merged[31:0];
    end else if (state == ST_PAD) begin
      we    = 1'b1;
      waddr = padw;
      if (padw == 4'd14 && !need_two) wdata = bitlen[31:0];
      else if (padw == 4'd15 && !need_two) wdata = bitlen[63:32];
      else wdata = word_hold;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser != OP_START) begin
          if (fill_sum[6]) state_next = ST_ROUND;
          else if (s_axis_tlast && fill[5:2] == 4'd15) state_next = ST_ROUND;
          else if (s_axis_tlast) state_next = ST_PAD;
        end
      end
      ST_PAD: if (padw == 4'd15) state_next = ST_ROUND;
      ST_ROUND: if (step == 7'd64) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!final_blk) state_next = ST_IDLE;
        else if (need_two) state_next = ST_PAD;
        else state_next = ST_OUT;
      end
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    m_axis_tdata  = {h[3], h[2], h[1], h[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
      fill      <= '0;
      bitlen    <= '0;
      step      <= '0;
      padw      <= '0;
      final_blk <= 1'b0;
      need_two  <= 1'b0;
      word_hold <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (in_fire && s_axis_tuser == OP_START) begin
            h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
            fill <= '0;
            bitlen <= '0;
            word_hold <= '0;
          end else if (in_fire) begin
            bitlen <= bitlen + {58'd0, nv, 3'd0};
            word_hold <= (crossed || s_axis_tlast) ? merged[63:32] : merged[31:0];
            fill <= fill_sum[5:0];
            final_blk <= s_axis_tlast;
            // marker byte and length must fit after the data
            need_two <= s_axis_tlast && (fill_sum >= 7'd56);
            padw <= fill[5:2] + 4'd1;
            ra <= h[0]; rb <= h[1]; rc <= h[2]; rd <= h[3];
          end
        end
        ST_PAD: begin
          padw <= padw + 4'd1;
          step <= '0;
          word_hold <= '0;
          ra <= h[0]; rb <= h[1]; rc <= h[2]; rd <= h[3];
        end
        ST_ROUND: begin
          step <= step + 7'd1;
          if (step != 7'd0) begin
            ra <= rd; rd <= rc; rc <= rb; rb <= b_new;
          end
        end
        ST_FOLD: begin
          h[0] <= h[0] + ra; h[1] <= h[1] + rb;
          h[2] <= h[2] + rc; h[3] <= h[3] + rd;
          if (final_blk && need_two) begin
            need_two <= 1'b0;
            padw <= '0;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            h[0] <= IV_A; h[1] <= IV_B; h[2] <= IV_C; h[3] <= IV_D;
            fill <= '0;
            bitlen <= '0;
            final_blk <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/md5sh_checker.sv
// Port checker for the MD5 stream hasher, bound to the top level.
// Depends on md5_stream_hasher ports only.
module md5sh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  // input and output are never open together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while digest pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest dropped during stall");

  a_back: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready)
    else $error("not idle after digest transfer");

  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("digest valid after reset");
endmodule

bind md5_stream_hasher md5sh_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

### tb/tb_md5_stream_hasher.sv
// Self-checking testbench for md5_stream_hasher: drives message streams on
// s_axis, predicts digests with a behavioural MD5 and checks m_axis.
// Depends on md5sh_pkg and the md5_stream_hasher RTL.
`timescale 1ns / 1ps

module tb_md5_stream_hasher
  import md5sh_pkg::*;
();

  typedef struct packed {
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } digest_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  md5_stream_hasher DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  localparam int IDLE_LIMIT = 20000;

  // predictor state
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  int unsigned fill;
  logic [63:0] bit_len;

  digest_t     digest_q [$];
  int          errors;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic int shift_of(input int i);
    int tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return tab[(i / 16) * 4 + (i % 4)];
  endfunction

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int g;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = a + f + blk[g] + K_TAB[i];
      t = b + rotl(t, shift_of(i));
      a = d; d = c; c = b; b = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic put_byte(input int pos, input logic [7:0] v);
    blk[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  task automatic restart_message();
    chain[0] = IV_A; chain[1] = IV_B; chain[2] = IV_C; chain[3] = IV_D;
    fill = 0;
    bit_len = '0;
  endtask

  task automatic predict_digest(input logic op, input logic [31:0] word,
                                input logic [2:0] nbytes, input logic lst);
    int n;
    digest_t dg;
    if (op == OP_START) begin
      restart_message();
      return;
    end
    n = (nbytes > 4) ? 4 : nbytes;
    for (int i = 0; i < n; i++) begin
      put_byte(fill, word[8 * i +: 8]);
      fill++;
      bit_len += 8;
      if (fill == 64) begin
        md5_compress();
        fill = 0;
      end
    end
    if (!lst) return;
    put_byte(fill, PAD_BYTE);
    for (int i = fill + 1; i < 64; i++) put_byte(i, 8'h00);
    if (fill + 1 > 56) begin
      md5_compress();
      for (int i = 0; i < 14; i++) blk[i] = '0;
    end
    blk[14] = bit_len[31:0];
    blk[15] = bit_len[63:32];
    md5_compress();
    dg.a = chain[0]; dg.b = chain[1]; dg.c = chain[2]; dg.d = chain[3];
    digest_q.push_back(dg);
    restart_message();
  endtask

  // offer one item, hold until the transfer, then predict; valid stays up
  // for a following item and drops only in idle cycles
  task automatic send_item(input logic op, input logic [31:0] word,
                           input logic [2:0] nbytes, input logic lst);
    while (($urandom % 100) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, nbytes, word};
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    predict_digest(op, word, nbytes, lst);
  endtask

  task automatic send_message(input int nwords, input logic [2:0] tail);
    for (int i = 0; i < nwords - 1; i++) send_item(1'b1, $urandom, 3'd4, 1'b0);
    send_item(1'b1, $urandom, tail, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_off && (($urandom % 100) >= recv_stall_pct);
  end

  // digest checker and watchdog
  always @(posedge clk) begin
    digest_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest %h", $time, got);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (got.a !== want.a) begin
            $display("%0t: digest_a expected %h actual %h", $time, want.a, got.a);
            errors++;
          end
          if (got.b !== want.b) begin
            $display("%0t: digest_b expected %h actual %h", $time, want.b, got.b);
            errors++;
          end
          if (got.c !== want.c) begin
            $display("%0t: digest_c expected %h actual %h", $time, want.c, got.c);
            errors++;
          end
          if (got.d !== want.d) begin
            $display("%0t: digest_d expected %h actual %h", $time, want.d, got.d);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_message(1, 3'd0);                 // empty message
    send_message(1, 3'd3);                 // "abc"-sized
    send_item(1'b1, 32'hffffffff, 3'd4, 1'b0);
    send_item(1'b0, 32'hffffffff, 3'd7, 1'b1); // start drops a partial message
    send_message(14, 3'd4);                // 56 bytes: second pad block
    send_message(14, 3'd3);                // 55 bytes: single pad block
    send_message(16, 3'd4);                // exactly one block
    send_item(1'b1, 32'h00000000, 3'd2, 1'b0); // short word mid-stream
    send_item(1'b1, 32'hdeadbeef, 3'd7, 1'b0); // saturates to four
    send_item(1'b1, 32'h12345678, 3'd5, 1'b1);
    send_item(1'b1, 32'h00000000, 3'd6, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      if (($urandom % 10) == 0) begin
        send_item(1'b0, $urandom, 3'($urandom_range(0, 7)), 1'($urandom % 2));
        sent++;
      end else begin
        n = (($urandom % 8) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 17);
        for (int i = 0; i < n - 1; i++) begin
          if (($urandom % 12) == 0)
            send_item(1'b1, $urandom, 3'($urandom_range(0, 7)), 1'b0);
          else send_item(1'b1, $urandom, 3'd4, 1'b0);
        end
        send_item(1'b1, $urandom, 3'($urandom_range(0, 7)), 1'b1);
        sent += n;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(3, 3'd1);
        send_message(2, 3'd4);
      end
    join
    wait_drained();
    repeat (300) @(posedge clk);          // sender pause with nothing pending
    send_message(20, 3'd2);
    wait_drained();
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    restart_message();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(220);
    send_idle_pct = 55;
    test_random(220);
    send_idle_pct = 0;
    recv_stall_pct = 55;
    test_random(220);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    test_random(220);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    repeat (200) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
